[sv/tlqe_pkg.sv]
// Shared constants and types for the thick line quad expander.
// Depends on nothing; used by the divider, the top level and the testbench.
`default_nettype none
package tlqe_pkg;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COORD_BITS_DEF = 32;
   localparam int IN_BITS        = 32;
   localparam int HW_BITS        = 31;
   localparam int IDX_BITS       = 3;
   localparam int NORM_BITS      = 31;

   localparam logic OP_PLAIN  = 1'b0;
   localparam logic OP_CAPPED = 1'b1;

   // Sideband that travels with every segment through the pipeline.
   typedef struct packed {
      logic        capped;
      logic        degen;
      logic        neg_x;
      logic        neg_y;
      logic signed [IN_BITS-1:0] bx;
      logic signed [IN_BITS-1:0] by;
      logic signed [IN_BITS-1:0] ex;
      logic signed [IN_BITS-1:0] ey;
      logic [HW_BITS-1:0]        hw;
   } seg_type;
endpackage
`default_nettype wire

[sv/tlqe_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, valid bits travel along.
// Depends on tlqe_pkg for the segment sideband type.
`default_nettype none
module tlqe_divider #(
   parameter int NUM_BITS = 48,
   parameter int DEN_BITS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  wire                   in_valid,
   input  wire [NUM_BITS-1:0]    in_num_a,
   input  wire [NUM_BITS-1:0]    in_num_b,
   input  wire [DEN_BITS-1:0]    in_den,
   input  tlqe_pkg::seg_type     in_seg,
   output logic                  out_valid,
   output logic [NUM_BITS-1:0]   out_quo_a,
   output logic [NUM_BITS-1:0]   out_quo_b,
   output tlqe_pkg::seg_type     out_seg
);
   localparam int REM_BITS = DEN_BITS + 1;

   logic [NUM_BITS:0]     v_ff;
   logic [NUM_BITS-1:0]   na_ff  [NUM_BITS+1];
   logic [NUM_BITS-1:0]   nb_ff  [NUM_BITS+1];
   logic [REM_BITS-1:0]   ra_ff  [NUM_BITS+1];
   logic [REM_BITS-1:0]   rb_ff  [NUM_BITS+1];
   logic [DEN_BITS-1:0]   d_ff   [NUM_BITS+1];
   tlqe_pkg::seg_type     s_ff   [NUM_BITS+1];

   // Stage zero loads the operands; each later stage retires one bit of both quotients.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[NUM_BITS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         na_ff[0] <= in_num_a;
         nb_ff[0] <= in_num_b;
         ra_ff[0] <= '0;
         rb_ff[0] <= '0;
         d_ff[0]  <= in_den;
         s_ff[0]  <= in_seg;
      end
   end

   for (genvar g = 0; g < NUM_BITS; g++) begin : g_step
      logic [REM_BITS:0] ta, tb;
      logic              ga, gb;
      assign ta = {ra_ff[g], na_ff[g][NUM_BITS-1]};
      assign tb = {rb_ff[g], nb_ff[g][NUM_BITS-1]};
      assign ga = ta >= {2'b00, d_ff[g]};
      assign gb = tb >= {2'b00, d_ff[g]};
      always_ff @(posedge clock) begin
         if (advance) begin
            ra_ff[g+1] <= ga ? REM_BITS'(ta - {2'b00, d_ff[g]}) : REM_BITS'(ta);
            rb_ff[g+1] <= gb ? REM_BITS'(tb - {2'b00, d_ff[g]}) : REM_BITS'(tb);
            na_ff[g+1] <= {na_ff[g][NUM_BITS-2:0], ga};
            nb_ff[g+1] <= {nb_ff[g][NUM_BITS-2:0], gb};
            d_ff[g+1]  <= d_ff[g];
            s_ff[g+1]  <= s_ff[g];
         end
      end
   end

   assign out_valid = v_ff[NUM_BITS];
   assign out_quo_a = na_ff[NUM_BITS];
   assign out_quo_b = nb_ff[NUM_BITS];
   assign out_seg   = s_ff[NUM_BITS];
endmodule
`default_nettype wire

[sv/thick_line_quad_expander_unit.sv]
// Thick line quad expander: a segment is normalized, scaled and emitted as vertices.
// The vertex emitter holds one segment at a time and emits 4 (plain) or 8 (capped) vertices for it.
// The front pipeline takes a segment every cycle while it is not stalled.
// Reset is synchronous and clears all valid bits; payload registers are not reset.
// Depends on tlqe_pkg and tlqe_divider.
`default_nettype none
module thick_line_quad_expander_unit #(
   parameter int FRAC_BITS  = tlqe_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = tlqe_pkg::COORD_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_op,
   input  wire  [31:0] req_begin_x,
   input  wire  [31:0] req_begin_y,
   input  wire  [31:0] req_end_x,
   input  wire  [31:0] req_end_y,
   input  wire  [30:0] req_half_width,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [2:0]  rsp_vertex_index,
   output logic [31:0] rsp_vertex_x,
   output logic [31:0] rsp_vertex_y,
   output logic        rsp_degenerate,
   output logic        rsp_last
);
   localparam int NB   = tlqe_pkg::NORM_BITS + 1;       // 32-bit normalized magnitudes
   localparam int DB   = tlqe_pkg::IN_BITS + 1;         // 33-bit deltas
   localparam int SQB  = 2 * NB + 2;                    // radicand width
   localparam int SQS  = SQB / 2;                       // square root steps
   localparam int QB   = NB + FRAC_BITS;                // dividend width
   localparam int PB   = QB + tlqe_pkg::HW_BITS;        // product width
   localparam int SB   = 36;                            // side magnitude width
   // Sum width: wide enough for every sum and for the saturation bounds.
   localparam int VB   = (COORD_BITS + 1 > 40) ? COORD_BITS + 1 : 40;
   localparam logic signed [VB-1:0] SAT_HI = VB'((64'sd1 <<< (COORD_BITS-1)) - 1);
   localparam logic signed [VB-1:0] SAT_LO = -SAT_HI - VB'(1);

   logic stall;
   logic adv;
   assign adv = !stall;
   assign req_ready = adv;

   // Stage A: deltas, degenerate test and absolute values.
   logic                 a_v_ff;
   tlqe_pkg::seg_type    a_s_ff;
   logic [DB-1:0]        a_ax_ff, a_ay_ff;
   logic signed [DB-1:0] dx, dy;
   assign dx = DB'($signed(req_end_x)) - DB'($signed(req_begin_x));
   assign dy = DB'($signed(req_end_y)) - DB'($signed(req_begin_y));
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (adv) a_v_ff <= req_valid && req_ready;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         a_s_ff.capped <= req_op == tlqe_pkg::OP_CAPPED;
         a_s_ff.degen  <= dx == '0 && dy == '0;
         a_s_ff.neg_x  <= dx[DB-1];
         a_s_ff.neg_y  <= dy[DB-1];
         a_s_ff.bx     <= req_begin_x;
         a_s_ff.by     <= req_begin_y;
         a_s_ff.ex     <= req_end_x;
         a_s_ff.ey     <= req_end_y;
         a_s_ff.hw     <= req_half_width;
         a_ax_ff       <= dx[DB-1] ? DB'(-dx) : DB'(dx);
         a_ay_ff       <= dy[DB-1] ? DB'(-dy) : DB'(dy);
      end
   end

   // Stage B: leading-one position of the larger magnitude.
   logic                 b_v_ff;
   tlqe_pkg::seg_type    b_s_ff;
   logic [DB-1:0]        b_ax_ff, b_ay_ff;
   logic [5:0]           b_lz_ff;
   logic [DB-1:0]        mor;
   logic [5:0]           lz;
   assign mor = a_ax_ff | a_ay_ff;
   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < DB; i++) begin
         if (mor[i]) lz = 6'(i);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (adv) b_v_ff <= a_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_s_ff  <= a_s_ff;
         b_ax_ff <= a_ax_ff;
         b_ay_ff <= a_ay_ff;
         b_lz_ff <= lz;
      end
   end

   // Stage C: shift so that the larger magnitude has its top bit at bit 30.
   logic                 c_v_ff;
   tlqe_pkg::seg_type    c_s_ff;
   logic [NB-1:0]        c_ax_ff, c_ay_ff;
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (adv) c_v_ff <= b_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_s_ff <= b_s_ff;
         if (b_lz_ff >= 6'd30) begin
            c_ax_ff <= NB'(b_ax_ff >> (b_lz_ff - 6'd30));
            c_ay_ff <= NB'(b_ay_ff >> (b_lz_ff - 6'd30));
         end else begin
            c_ax_ff <= NB'(b_ax_ff << (6'd30 - b_lz_ff));
            c_ay_ff <= NB'(b_ay_ff << (6'd30 - b_lz_ff));
         end
      end
   end

   // Stage D: squares, one multiplier per axis.
   logic                 d_v_ff;
   tlqe_pkg::seg_type    d_s_ff;
   logic [NB-1:0]        d_ax_ff, d_ay_ff;
   logic [2*NB-1:0]      d_sx_ff, d_sy_ff;
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else if (adv) d_v_ff <= c_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d_s_ff  <= c_s_ff;
         d_ax_ff <= c_ax_ff;
         d_ay_ff <= c_ay_ff;
         d_sx_ff <= c_ax_ff * c_ax_ff;
         d_sy_ff <= c_ay_ff * c_ay_ff;
      end
   end

   // Square root pipeline: one result bit per stage.
   logic [SQS:0]         q_v_ff;
   tlqe_pkg::seg_type    q_s_ff  [SQS+1];
   logic [NB-1:0]        q_ax_ff [SQS+1];
   logic [NB-1:0]        q_ay_ff [SQS+1];
   logic [SQB-1:0]       q_rad_ff[SQS+1];
   logic [SQS+1:0]       q_rem_ff[SQS+1];
   logic [SQS-1:0]       q_root_ff[SQS+1];
   always_ff @(posedge clock) begin
      if (reset) q_v_ff <= '0;
      else if (adv) q_v_ff <= {q_v_ff[SQS-1:0], d_v_ff};
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         q_s_ff[0]    <= d_s_ff;
         q_ax_ff[0]   <= d_ax_ff;
         q_ay_ff[0]   <= d_ay_ff;
         q_rad_ff[0]  <= SQB'(d_sx_ff) + SQB'(d_sy_ff);
         q_rem_ff[0]  <= '0;
         q_root_ff[0] <= '0;
      end
   end
   for (genvar g = 0; g < SQS; g++) begin : g_sqrt
      logic [SQS+1:0] rem_sh, trial;
      logic           take;
      assign rem_sh = {q_rem_ff[g][SQS-1:0], q_rad_ff[g][SQB-1 -: 2]};
      assign trial  = {q_root_ff[g], 2'b01};
      assign take   = rem_sh >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            q_s_ff[g+1]    <= q_s_ff[g];
            q_ax_ff[g+1]   <= q_ax_ff[g];
            q_ay_ff[g+1]   <= q_ay_ff[g];
            q_rad_ff[g+1]  <= {q_rad_ff[g][SQB-3:0], 2'b00};
            q_rem_ff[g+1]  <= take ? rem_sh - trial : rem_sh;
            q_root_ff[g+1] <= {q_root_ff[g][SQS-2:0], take};
         end
      end
   end

   // Stage E: dividends with half the length added for rounding.
   logic                 e_v_ff;
   tlqe_pkg::seg_type    e_s_ff;
   logic [QB-1:0]        e_na_ff, e_nb_ff;
   logic [NB-1:0]        e_len_ff;
   logic [NB-1:0]        len_c;
   assign len_c = (q_root_ff[SQS] == '0) ? NB'(1) : NB'(q_root_ff[SQS]);
   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else if (adv) e_v_ff <= q_v_ff[SQS];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         e_s_ff   <= q_s_ff[SQS];
         e_len_ff <= len_c;
         e_na_ff  <= {q_ax_ff[SQS], FRAC_BITS'(0)} + QB'(len_c >> 1);
         e_nb_ff  <= {q_ay_ff[SQS], FRAC_BITS'(0)} + QB'(len_c >> 1);
      end
   end

   logic                 v_v;
   logic [QB-1:0]        v_ux, v_uy;
   tlqe_pkg::seg_type    v_s;
   tlqe_divider #(.NUM_BITS(QB), .DEN_BITS(NB)) u_div (
      .clock(clock), .reset(reset), .advance(adv),
      .in_valid(e_v_ff), .in_num_a(e_na_ff), .in_num_b(e_nb_ff),
      .in_den(e_len_ff), .in_seg(e_s_ff),
      .out_valid(v_v), .out_quo_a(v_ux), .out_quo_b(v_uy), .out_seg(v_s)
   );

   // Stage F: scale the unit vector by the half width.
   logic                 f_v_ff;
   tlqe_pkg::seg_type    f_s_ff;
   logic [PB-1:0]        f_px_ff, f_py_ff;
   logic [NB-1:0]        ux_n, uy_n;
   assign ux_n = NB'(v_ux);
   assign uy_n = NB'(v_uy);
   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else if (adv) f_v_ff <= v_v;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         f_s_ff  <= v_s;
         f_px_ff <= PB'(ux_n) * PB'(v_s.hw);
         f_py_ff <= PB'(uy_n) * PB'(v_s.hw);
      end
   end

   // Stage G: round, apply signs and build the normal and corner offsets.
   logic                 g_v_ff;
   tlqe_pkg::seg_type    g_s_ff;
   logic signed [VB-1:0] g_nx_ff, g_ny_ff, g_nwx_ff, g_nwy_ff, g_nex_ff, g_ney_ff;
   logic [PB-1:0]        rx, ry;
   logic signed [VB-1:0] sx, sy;
   assign rx = (f_px_ff + PB'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
   assign ry = (f_py_ff + PB'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
   always_comb begin
      sx = f_s_ff.neg_x ? -$signed(VB'(SB'(rx))) : $signed(VB'(SB'(rx)));
      sy = f_s_ff.neg_y ? -$signed(VB'(SB'(ry))) : $signed(VB'(SB'(ry)));
      if (f_s_ff.degen) begin
         sx = '0;
         sy = '0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) g_v_ff <= 1'b0;
      else if (adv) g_v_ff <= f_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         g_s_ff   <= f_s_ff;
         g_nx_ff  <= -sy;
         g_ny_ff  <= sx;
         g_nwx_ff <= -sy - sx;
         g_nwy_ff <= sx - sy;
         g_nex_ff <= -sy + sx;
         g_ney_ff <= sx + sy;
      end
   end

   // Emitter: holds one segment and walks through its vertices.
   logic                 h_v_ff;
   tlqe_pkg::seg_type    h_s_ff;
   logic signed [VB-1:0] h_nx_ff, h_ny_ff, h_nwx_ff, h_nwy_ff, h_nex_ff, h_ney_ff;
   logic [tlqe_pkg::IDX_BITS-1:0] k_ff;
   logic                 last_k, emit, load;
   logic                 o_v_ff;
   logic signed [VB-1:0] px, py, ox, oy, tx, ty;

   assign last_k = h_s_ff.capped ? (k_ff == 3'd7) : (k_ff == 3'd3);
   assign emit   = h_v_ff && (!o_v_ff || rsp_ready);
   assign load   = !h_v_ff || (emit && last_k);
   assign stall  = g_v_ff && !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff <= 1'b0;
         k_ff   <= '0;
      end else begin
         if (load) begin
            h_v_ff <= g_v_ff;
            k_ff   <= '0;
         end else if (emit) begin
            k_ff <= k_ff + 3'd1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (load) begin
         h_s_ff   <= g_s_ff;
         h_nx_ff  <= g_nx_ff;
         h_ny_ff  <= g_ny_ff;
         h_nwx_ff <= g_nwx_ff;
         h_nwy_ff <= g_nwy_ff;
         h_nex_ff <= g_nex_ff;
         h_ney_ff <= g_ney_ff;
      end
   end

   // Select base point and offset for the current vertex.
   always_comb begin
      if (h_s_ff.capped) begin
         px = (k_ff < 3'd4) ? VB'(h_s_ff.bx) : VB'(h_s_ff.ex);
         py = (k_ff < 3'd4) ? VB'(h_s_ff.by) : VB'(h_s_ff.ey);
         unique case (k_ff)
            3'd0: begin ox = -h_nex_ff; oy = -h_ney_ff; end
            3'd1: begin ox = h_nwx_ff;  oy = h_nwy_ff;  end
            3'd2: begin ox = -h_nx_ff;  oy = -h_ny_ff;  end
            3'd3: begin ox = h_nx_ff;   oy = h_ny_ff;   end
            3'd4: begin ox = -h_nx_ff;  oy = -h_ny_ff;  end
            3'd5: begin ox = h_nx_ff;   oy = h_ny_ff;   end
            3'd6: begin ox = -h_nwx_ff; oy = -h_nwy_ff; end
            default: begin ox = h_nex_ff; oy = h_ney_ff; end
         endcase
      end else begin
         px = (k_ff < 3'd2) ? VB'(h_s_ff.bx) : VB'(h_s_ff.ex);
         py = (k_ff < 3'd2) ? VB'(h_s_ff.by) : VB'(h_s_ff.ey);
         ox = k_ff[0] ? h_nx_ff : -h_nx_ff;
         oy = k_ff[0] ? h_ny_ff : -h_ny_ff;
      end
      tx = px + ox;
      ty = py + oy;
      if (tx > SAT_HI) tx = SAT_HI;
      else if (tx < SAT_LO) tx = SAT_LO;
      if (ty > SAT_HI) ty = SAT_HI;
      else if (ty < SAT_LO) ty = SAT_LO;
   end

   // Output register: one vertex transaction at a time.
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (emit) o_v_ff <= 1'b1;
      else if (rsp_ready) o_v_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_vertex_index <= k_ff;
         rsp_vertex_x     <= tx[31:0];
         rsp_vertex_y     <= ty[31:0];
         rsp_degenerate   <= h_s_ff.degen;
         rsp_last         <= last_k;
      end
   end
   assign rsp_valid = o_v_ff;
endmodule
`default_nettype wire

[sv/tlqe_checker.sv]
// Port-level checker for the thick line quad expander, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module tlqe_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_vertex_index,
   input wire [31:0] rsp_vertex_x,
   input wire        rsp_last
);
   // A result that is not taken stays valid and holds its x coordinate.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_x))
      else $error("stalled vertex changed");
   // The last vertex of a segment is always index 3 or index 7.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_vertex_index == 3'd3 || rsp_vertex_index == 3'd7)
      else $error("last on wrong index");
   // After a last vertex the next segment starts at index zero.
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last ##1 rsp_valid |-> rsp_vertex_index == 3'd0)
      else $error("segment did not start at zero");
   // Index three is last, or is followed by index four.
   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last && rsp_vertex_index == 3'd3 ##1 rsp_valid
      |-> rsp_vertex_index == 3'd4)
      else $error("vertex order broken");
endmodule

bind thick_line_quad_expander_unit tlqe_checker u_tlqe_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_vertex_index(rsp_vertex_index), .rsp_vertex_x(rsp_vertex_x),
   .rsp_last(rsp_last)
);
`default_nettype wire

[verif/thick_line_quad_expander_unit_test.sv]
// Self-checking testbench for the thick line quad expander unit.
// Depends on tlqe_pkg and the block's RTL; a scoreboard class predicts each vertex.
`timescale 1ns / 100ps

// Predicts the vertex strip of every accepted segment and checks results in order.
class vertex_scoreboard;
   typedef struct {
      logic [2:0]  index;
      logic [31:0] x;
      logic [31:0] y;
      logic        degen;
      logic        last;
   } vertex_type;

   vertex_type pending_vertices[$];
   int         error_count;

   function longint clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< 31) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function void push_vertex(int k, int n, longint bx, longint by, longint ox, longint oy,
                             logic degen);
      vertex_type v;
      v.index = k[2:0];
      v.x     = 32'(clamp_coord(bx + ox));
      v.y     = 32'(clamp_coord(by + oy));
      v.degen = degen;
      v.last  = (k == n - 1);
      pending_vertices.push_back(v);
   endfunction

   // Notes an accepted segment and queues the vertices it must produce.
   function void note_segment(logic op, logic [31:0] bxr, logic [31:0] byr,
                              logic [31:0] exr, logic [31:0] eyr, logic [30:0] hw);
      longint bx, by, ex, ey, dx, dy, sx, sy, nx, ny, nwx, nwy, nex, ney;
      longint unsigned ax, ay, m, len, ux, uy, w;
      logic degen;
      bx = longint'(signed'(bxr));
      by = longint'(signed'(byr));
      ex = longint'(signed'(exr));
      ey = longint'(signed'(eyr));
      w  = longint'(hw);
      dx = ex - bx;
      dy = ey - by;
      degen = (dx == 0 && dy == 0);
      sx = 0;
      sy = 0;
      if (!degen) begin
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         m  = (ax > ay) ? ax : ay;
         while (m < (64'd1 << 30)) begin
            ax = ax << 1; ay = ay << 1; m = m << 1;
         end
         while (m >= (64'd1 << 31)) begin
            ax = ax >> 1; ay = ay >> 1; m = m >> 1;
         end
         len = root_floor(ax * ax + ay * ay);
         if (len == 0) len = 1;
         ux = ((ax << 16) + len / 2) / len;
         uy = ((ay << 16) + len / 2) / len;
         sx = longint'((ux * w + (64'd1 << 15)) >> 16);
         sy = longint'((uy * w + (64'd1 << 15)) >> 16);
         if (dx < 0) sx = -sx;
         if (dy < 0) sy = -sy;
      end
      nx = -sy; ny = sx;
      nwx = nx - sx; nwy = ny - sy;
      nex = nx + sx; ney = ny + sy;
      if (op == tlqe_pkg::OP_PLAIN) begin
         push_vertex(0, 4, bx, by, -nx, -ny, degen);
         push_vertex(1, 4, bx, by, nx, ny, degen);
         push_vertex(2, 4, ex, ey, -nx, -ny, degen);
         push_vertex(3, 4, ex, ey, nx, ny, degen);
      end else begin
         push_vertex(0, 8, bx, by, -nex, -ney, degen);
         push_vertex(1, 8, bx, by, nwx, nwy, degen);
         push_vertex(2, 8, bx, by, -nx, -ny, degen);
         push_vertex(3, 8, bx, by, nx, ny, degen);
         push_vertex(4, 8, ex, ey, -nx, -ny, degen);
         push_vertex(5, 8, ex, ey, nx, ny, degen);
         push_vertex(6, 8, ex, ey, -nwx, -nwy, degen);
         push_vertex(7, 8, ex, ey, nex, ney, degen);
      end
   endfunction

   // Compares one vertex against the oldest expectation.
   function void check_vertex(logic [2:0] index, logic [31:0] x, logic [31:0] y,
                              logic degen, logic last);
      vertex_type v;
      if (pending_vertices.size() == 0) begin
         $error("unexpected vertex index=%0d x=%h y=%h", index, x, y);
         error_count++;
         return;
      end
      v = pending_vertices.pop_front();
      if (index !== v.index) begin
         $error("vertex_index expected %0d actual %0d", v.index, index);
         error_count++;
      end
      if (x !== v.x) begin
         $error("vertex_x expected %h actual %h", v.x, x);
         error_count++;
      end
      if (y !== v.y) begin
         $error("vertex_y expected %h actual %h", v.y, y);
         error_count++;
      end
      if (degen !== v.degen) begin
         $error("degenerate expected %0b actual %0b", v.degen, degen);
         error_count++;
      end
      if (last !== v.last) begin
         $error("last expected %0b actual %0b", v.last, last);
         error_count++;
      end
   endfunction
endclass

module thick_line_quad_expander_unit_test;
   localparam int RANDOM_SEGMENTS = 290;
   localparam int STALL_LIMIT     = 20000;
   localparam int DRAIN_CYCLES    = 400;
   localparam int LONG_HOLD       = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = tlqe_pkg::OP_PLAIN;
   logic [31:0] req_begin_x = '0;
   logic [31:0] req_begin_y = '0;
   logic [31:0] req_end_x = '0;
   logic [31:0] req_end_y = '0;
   logic [30:0] req_half_width = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_vertex_index;
   logic [31:0] rsp_vertex_x;
   logic [31:0] rsp_vertex_y;
   logic        rsp_degenerate;
   logic        rsp_last;

   vertex_scoreboard scoreboard = new();
   bit  quiet_phase = 1'b0;
   bit  long_hold_done = 1'b0;
   int  idle_cycles = 0;

   thick_line_quad_expander_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_begin_x(req_begin_x), .req_begin_y(req_begin_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .req_half_width(req_half_width),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_vertex_index(rsp_vertex_index), .rsp_vertex_x(rsp_vertex_x),
      .rsp_vertex_y(rsp_vertex_y), .rsp_degenerate(rsp_degenerate),
      .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   // Sample both channels at the edge; note inputs and check results.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            scoreboard.note_segment(req_op, req_begin_x, req_begin_y, req_end_x,
                                    req_end_y, req_half_width);
         if (rsp_valid && rsp_ready)
            scoreboard.check_vertex(rsp_vertex_index, rsp_vertex_x, rsp_vertex_y,
                                    rsp_degenerate, rsp_last);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog on cycles with no transaction at all.
   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: one long hold-off first, long enough to fill the pipeline,
   // then random stall bursts.
   initial begin : receiver
      int n;
      @(posedge clock iff !reset);
      repeat (LONG_HOLD) @(posedge clock);
      long_hold_done = 1'b1;
      rsp_ready <= 1'b1;
      forever begin
         n = $urandom_range(1, 40);
         repeat (n) @(posedge clock);
         if (!quiet_phase && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one segment and holds it until accepted, with an optional gap before.
   task automatic send_segment(logic op, logic [31:0] bx, logic [31:0] by,
                               logic [31:0] ex, logic [31:0] ey, logic [30:0] hw);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_begin_x    <= bx;
      req_begin_y    <= by;
      req_end_x      <= ex;
      req_end_y      <= ey;
      req_half_width <= hw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Coordinates are mostly small so normalization is meaningful, sometimes full range.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      endcase
   endfunction

   function automatic logic [30:0] pick_width();
      case ($urandom_range(0, 4))
         0: return 31'($urandom());
         1: return 31'h7FFF_FFFF;
         2: return '0;
         default: return 31'($urandom_range(0, 32'h0010_0000));
      endcase
   endfunction

   initial begin : sender
      logic [31:0] bx, by;
      int          wait_count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, both ops, zero length, zero width, saturation.
      send_segment(tlqe_pkg::OP_PLAIN,  32'h0, 32'h0, 32'h0001_0000, 32'h0, 31'h0001_0000);
      send_segment(tlqe_pkg::OP_CAPPED, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 31'h0001_0000);
      send_segment(tlqe_pkg::OP_CAPPED, 32'h0005_0000, 32'hFFFD_0000, 32'h0005_0000,
                   32'hFFFD_0000, 31'h0002_0000);
      send_segment(tlqe_pkg::OP_PLAIN,  32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                   32'h1234_5678, 31'h7FFF_FFFF);
      send_segment(tlqe_pkg::OP_CAPPED, 32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 31'h0);
      send_segment(tlqe_pkg::OP_CAPPED, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 31'h7FFF_FFFF);
      send_segment(tlqe_pkg::OP_PLAIN,  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 31'h7FFF_FFFF);
      send_segment(tlqe_pkg::OP_CAPPED, 32'h7FFF_0000, 32'h0, 32'h7FFF_FFFF, 32'h0,
                   31'h4000_0000);
      send_segment(tlqe_pkg::OP_CAPPED, 32'h8001_0000, 32'h0, 32'h8000_0000, 32'h0001,
                   31'h4000_0000);
      send_segment(tlqe_pkg::OP_PLAIN,  32'h0, 32'h0, 32'h1, 32'h1, 31'h0000_0001);
      send_segment(tlqe_pkg::OP_CAPPED, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 31'h5555_5555);
      send_segment(tlqe_pkg::OP_CAPPED, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h0000_0000, 31'h2AAA_AAAA);
      // Random segments; the receiver is held off during the first burst above.
      for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
         if (i == RANDOM_SEGMENTS - 40) quiet_phase = 1'b1;
         bx = pick_coord();
         by = pick_coord();
         if ($urandom_range(0, 15) == 0)
            send_segment(1'($urandom()), bx, by, bx, by, pick_width());
         else
            send_segment(1'($urandom()), bx, by, pick_coord(), pick_coord(), pick_width());
      end
      req_valid <= 1'b0;
      // Drain everything expected, then watch for stray vertices.
      wait_count = 0;
      while (scoreboard.pending_vertices.size() != 0 && wait_count < 200000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.error_count == 0 && scoreboard.pending_vertices.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

[filelist.f]
sv/tlqe_pkg.sv
sv/tlqe_divider.sv
sv/thick_line_quad_expander_unit.sv
sv/tlqe_checker.sv
verif/thick_line_quad_expander_unit_test.sv
